// ===== rtl/bls_pkg.sv =====
package bls_pkg;

    // Raster coordinate width and derived datapath widths
    localparam int unsigned COORD_BITS = 7;
    localparam int unsigned DELTA_BITS = COORD_BITS + 1;   // doubled deltas
    localparam int unsigned ERR_BITS   = COORD_BITS + 3;   // signed decision term
    localparam int unsigned COLOR_BITS = 8;
    localparam int unsigned VALUE_BITS = 4;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    // Beat kinds on the input channel
    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    // Accepted input beat
    typedef struct packed {
        kind_t  kind;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        color_t color;
    } in_beat_t;

    // One emitted pixel
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        value_t pixel_value;
        logic   last;
    } pixel_t;

endpackage

// ===== rtl/bls_core.sv =====
module bls_core
    import bls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  in_beat_t beat,
    output logic     has_pixel,
    output pixel_t   pixel
);

    // x mod 13 by reciprocal: floor(x * 79 / 1024) is exact for 8-bit x
    localparam int unsigned MOD_RECIP  = 79;
    localparam int unsigned MOD_SHIFT  = 10;
    localparam int unsigned VALUE_MOD  = 13;
    localparam int unsigned VALUE_BIAS = 3;
    localparam int unsigned PROD_BITS  = COLOR_BITS + 7;
    localparam int unsigned QUO_BITS   = PROD_BITS - MOD_SHIFT;
    localparam int unsigned ERR_PAD    = ERR_BITS - DELTA_BITS;
    localparam int unsigned ADX_PAD    = ERR_BITS - COORD_BITS;

    // Line state
    coord_t cur_x_reg, cur_y_reg, target_x_reg, target_y_reg;
    delta_t twice_dx_reg, twice_dy_reg;
    err_t   err_reg;
    logic   x_dec_reg, y_dec_reg, x_major_reg, active_reg;
    value_t held_value_reg;

    coord_t cur_x_next, cur_y_next, target_x_next, target_y_next;
    delta_t twice_dx_next, twice_dy_next;
    err_t   err_next;
    logic   x_dec_next, y_dec_next, x_major_next, active_next;
    value_t held_value_next;

    logic [PROD_BITS-1:0]  color_prod;
    logic [QUO_BITS-1:0]   color_quo;
    logic [COLOR_BITS-1:0] color_rem;
    coord_t adx, ady;
    err_t   dx_ext, dy_ext, err_after;
    logic   fin;

    function automatic coord_t step_coord(input coord_t c, input logic down);
        step_coord = down ? coord_t'(c - 1'b1) : coord_t'(c + 1'b1);
    endfunction

    // Pixel value from the colour code
    always_comb begin
        color_prod = PROD_BITS'(beat.color) * PROD_BITS'(MOD_RECIP);
        color_quo  = color_prod[PROD_BITS-1:MOD_SHIFT];
        color_rem  = beat.color - COLOR_BITS'(color_quo * COLOR_BITS'(VALUE_MOD));
    end

    // Start setup and one Bresenham step
    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        twice_dx_next   = twice_dx_reg;
        twice_dy_next   = twice_dy_reg;
        err_next        = err_reg;
        x_dec_next      = x_dec_reg;
        y_dec_next      = y_dec_reg;
        x_major_next    = x_major_reg;
        held_value_next = held_value_reg;
        adx             = '0;
        ady             = '0;
        dx_ext          = signed'({{ERR_PAD{1'b0}}, twice_dx_reg});
        dy_ext          = signed'({{ERR_PAD{1'b0}}, twice_dy_reg});
        err_after       = err_reg;

        if (beat.kind == KIND_START) begin
            x_dec_next    = beat.x_end < beat.x_start;
            y_dec_next    = beat.y_end < beat.y_start;
            adx           = x_dec_next ? coord_t'(beat.x_start - beat.x_end)
                                       : coord_t'(beat.x_end - beat.x_start);
            ady           = y_dec_next ? coord_t'(beat.y_start - beat.y_end)
                                       : coord_t'(beat.y_end - beat.y_start);
            twice_dx_next = {adx, 1'b0};
            twice_dy_next = {ady, 1'b0};
            x_major_next  = adx > ady;
            if (x_major_next) begin
                err_next = signed'({{ERR_PAD{1'b0}}, twice_dy_next})
                         - signed'({{ADX_PAD{1'b0}}, adx});
            end else begin
                err_next = signed'({{ERR_PAD{1'b0}}, twice_dx_next})
                         - signed'({{ADX_PAD{1'b0}}, ady});
            end
            held_value_next = (beat.color == '0) ? value_t'(1)
                : value_t'(color_rem[VALUE_BITS-1:0] + VALUE_BITS'(VALUE_BIAS));
            cur_x_next    = beat.x_start;
            cur_y_next    = beat.y_start;
            target_x_next = beat.x_end;
            target_y_next = beat.y_end;
        end else if (x_major_reg) begin
            if (!err_reg[ERR_BITS-1]) begin
                cur_y_next = step_coord(cur_y_reg, y_dec_reg);
                err_after  = err_reg - dx_ext;
            end
            cur_x_next = step_coord(cur_x_reg, x_dec_reg);
            err_next   = err_after + dy_ext;
        end else begin
            if (!err_reg[ERR_BITS-1]) begin
                cur_x_next = step_coord(cur_x_reg, x_dec_reg);
                err_after  = err_reg - dy_ext;
            end
            cur_y_next = step_coord(cur_y_reg, y_dec_reg);
            err_next   = err_after + dx_ext;
        end

        fin = x_major_next ? (cur_x_next == target_x_next)
                           : (cur_y_next == target_y_next);

        has_pixel   = (beat.kind == KIND_START) || active_reg;
        active_next = has_pixel ? !fin : active_reg;

        pixel.pixel_x     = cur_x_next;
        pixel.pixel_y     = cur_y_next;
        pixel.pixel_value = held_value_next;
        pixel.last        = fin;
    end

    // State update on each accepted beat that does work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            twice_dx_reg   <= '0;
            twice_dy_reg   <= '0;
            err_reg        <= '0;
            x_dec_reg      <= 1'b0;
            y_dec_reg      <= 1'b0;
            x_major_reg    <= 1'b0;
            active_reg     <= 1'b0;
            held_value_reg <= value_t'(1);
        end else if (fire && has_pixel) begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            twice_dx_reg   <= twice_dx_next;
            twice_dy_reg   <= twice_dy_next;
            err_reg        <= err_next;
            x_dec_reg      <= x_dec_next;
            y_dec_reg      <= y_dec_next;
            x_major_reg    <= x_major_next;
            active_reg     <= active_next;
            held_value_reg <= held_value_next;
        end
    end

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// Channel  Ports                                           Dir  Beat
// -------  ----------------------------------------------  ---  ---------------------------
// input    s_valid s_ready s_kind s_x_start s_y_start       in   start a line or advance it
//          s_x_end s_y_end s_color
// result   m_valid m_ready m_pixel_x m_pixel_y              out  one pixel, last on endpoint
//          m_pixel_value m_last
//
// One beat per clock while s_ready is high: each accepted beat is stepped combinationally
// from the line state registers into the result register, or into the skid entry.
// A two-entry output buffer (result register plus skid) keeps s_ready high while one
// finished pixel waits; s_ready drops only when both entries are full.
// Reset (aresetn low, synchronous) ends any line in progress and empties the buffer.
// An advance beat with no line in progress is accepted and produces no pixel.
module bresenham_line_stepper
    import bls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    input  logic [COLOR_BITS-1:0] s_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [VALUE_BITS-1:0] m_pixel_value,
    output logic                  m_last
);

    in_beat_t beat;
    pixel_t   pixel;
    logic     has_pixel, fire, push, pop;

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    pixel_t out_reg, out_next;
    pixel_t skid_reg, skid_next;

    assign beat.kind    = kind_t'(s_kind);
    assign beat.x_start = s_x_start;
    assign beat.y_start = s_y_start;
    assign beat.x_end   = s_x_end;
    assign beat.y_end   = s_y_end;
    assign beat.color   = s_color;

    assign s_ready = !skid_valid_reg;
    assign fire    = s_valid && s_ready;

    bls_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .beat      (beat),
        .has_pixel (has_pixel),
        .pixel     (pixel)
    );

    assign push = fire && has_pixel;
    assign pop  = out_valid_reg && m_ready;

    // Result register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next = pixel;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_next       = pixel;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = pixel;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_x     = out_reg.pixel_x;
    assign m_pixel_y     = out_reg.pixel_y;
    assign m_pixel_value = out_reg.pixel_value;
    assign m_last        = out_reg.last;

`ifndef ASSERT_OFF
    // Skid entry is only ever occupied behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // Skid fills only when the result register was stalled
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    // Draining a full buffer moves the skid beat forward and frees the skid
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg
            && out_reg == $past(skid_reg)))
        else $error("skid beat not forwarded on drain");
`endif

endmodule
